>>> sv/spq_pkg.sv
// Shared types, constants and helpers for the stable priority queue.
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 16;
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_NOTFOUND  = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]         key;
        logic [2:0]         prio;
        logic [ID_BITS-1:0] id;
        logic [7:0]         age;
        logic [1:0]         cond;
    } entry_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;    // capture input transaction
        logic       exec;    // apply the operation to the queue
    } dp_cmd_t;

    // Priority to condition code
    function automatic logic [1:0] cond_of(input logic [2:0] pr);
        logic [1:0] c;
        c = 2'd0;
        if (pr == 3'd1 || pr == 3'd2 || pr == 3'd3)
        begin
            c = pr[1:0];
        end
        return c;
    endfunction

endpackage

>>> sv/stable_priority_queue_top.sv
// Top level of the stable priority queue.
// Usage:
//  Input channel (in_valid/in_stall) carries one command transaction:
//  insert, remove front or update. The output channel (out_valid/out_stall)
//  returns exactly one result transaction per command with status, the
//  removed or updated entry, and the queue front and count after the step.
//  The queue is a 16-entry shift register kept in descending key order;
//  all slots compare in parallel.
//  A command is captured in S_IDLE and applied in S_EXEC, where its result
//  is registered; the result is offered in S_OUT. The controller takes a
//  new command only after the result is taken.
//  A stalled result holds its value until taken; in_stall stays high.
//  Reset empties the queue (count zero); entry contents are not cleared.
module stable_priority_queue_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [15:0] patient_id,
    input  logic [7:0]  patient_age,
    input  logic [2:0]  priority_req,
    input  logic [2:0]  new_priority,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] out_id,
    output logic [7:0]  out_age,
    output logic [2:0]  out_priority,
    output logic [1:0]  out_condition,
    output logic        front_valid,
    output logic [15:0] front_id,
    output logic [4:0]  entry_count
);

    spq_pkg::dp_cmd_t cmd_ctl;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd_ctl   (cmd_ctl)
    );

    spq_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_ctl       (cmd_ctl),
        .cmd           (cmd),
        .patient_id    (patient_id),
        .patient_age   (patient_age),
        .priority_req  (priority_req),
        .new_priority  (new_priority),
        .status        (status),
        .out_id        (out_id),
        .out_age       (out_age),
        .out_priority  (out_priority),
        .out_condition (out_condition),
        .front_valid   (front_valid),
        .front_id      (front_id),
        .entry_count   (entry_count)
    );

endmodule

>>> sv/spq_datapath.sv
// Shift-register entry array with parallel compare and result registers.
module spq_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  spq_pkg::dp_cmd_t              cmd_ctl,
    input  logic [1:0]                    cmd,
    input  logic [15:0]                   patient_id,
    input  logic [7:0]                    patient_age,
    input  logic [2:0]                    priority_req,
    input  logic [2:0]                    new_priority,
    output logic [1:0]                    status,
    output logic [15:0]                   out_id,
    output logic [7:0]                    out_age,
    output logic [2:0]                    out_priority,
    output logic [1:0]                    out_condition,
    output logic                          front_valid,
    output logic [15:0]                   front_id,
    output logic [4:0]                    entry_count
);

    localparam int D = spq_pkg::QUEUE_DEPTH;
    localparam int W = spq_pkg::ID_BITS;
    localparam int C = spq_pkg::CNT_BITS;

    spq_pkg::entry_t q_reg [D];
    logic [C-1:0]    occ_reg, occ_next;

    // Captured transaction
    logic [1:0]   cmd_reg;
    logic [W-1:0] id_reg;
    logic [7:0]   age_reg;
    logic [2:0]   prq_reg, npr_reg;

    logic [1:0]   status_reg;
    logic [15:0]  out_id_reg;
    logic [7:0]   out_age_reg;
    logic [2:0]   out_pr_reg;
    logic [1:0]   out_cond_reg;

    logic [D-1:0] live, ge, hit, first_hit;
    logic         found, full, empty;
    spq_pkg::entry_t ins_e, sel_e, upd_e;

    always_ff @(posedge clk)
    begin
        if (cmd_ctl.load)
        begin
            cmd_reg <= cmd;
            id_reg  <= patient_id[W-1:0];
            age_reg <= patient_age;
            prq_reg <= priority_req;
            npr_reg <= new_priority;
        end
    end

    // Per-slot compare
    always_comb
    begin
        for (int i = 0; i < D; i++)
        begin
            live[i] = (C'(i) < occ_reg);
            ge[i]   = live[i] && (q_reg[i].key >= prq_reg);
            hit[i]  = live[i] && (q_reg[i].id == id_reg) && (q_reg[i].age == age_reg)
                      && (q_reg[i].prio == prq_reg);
        end
        first_hit = hit & (~hit + D'(1));
        found = |hit;
        full  = (occ_reg == C'(D));
        empty = (occ_reg == '0);
        sel_e = '0;
        for (int i = 0; i < D; i++)
        begin
            if (first_hit[i])
            begin
                sel_e = q_reg[i];
            end
        end
        upd_e = sel_e;
        upd_e.prio = npr_reg;
        if (spq_pkg::cond_of(npr_reg) != 2'd0)
        begin
            upd_e.cond = spq_pkg::cond_of(npr_reg);
        end
        ins_e.key  = prq_reg;
        ins_e.prio = prq_reg;
        ins_e.id   = id_reg;
        ins_e.age  = age_reg;
        ins_e.cond = spq_pkg::cond_of(prq_reg);
    end

    // Entry array: shift on insert/remove, in-place write on update
    always_ff @(posedge clk)
    begin
        if (cmd_ctl.exec)
        begin
            for (int i = 0; i < D; i++)
            begin
                unique case (cmd_reg)
                    spq_pkg::CMD_INSERT:
                    begin
                        if (!full)
                        begin
                            if (!ge[i])
                            begin
                                if (i == 0)
                                begin
                                    q_reg[i] <= ins_e;
                                end
                                else if (ge[i-1])
                                begin
                                    q_reg[i] <= ins_e;
                                end
                                else if (live[i-1])
                                begin
                                    q_reg[i] <= q_reg[i-1];
                                end
                            end
                        end
                    end
                    spq_pkg::CMD_REMOVE:
                    begin
                        if (i < D - 1)
                        begin
                            q_reg[i] <= q_reg[i+1];
                        end
                    end
                    spq_pkg::CMD_UPDATE:
                    begin
                        if (first_hit[i])
                        begin
                            q_reg[i] <= upd_e;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Occupancy and result registers
    always_comb
    begin
        occ_next = occ_reg;
        case (cmd_reg)
            spq_pkg::CMD_INSERT: if (!full)  occ_next = occ_reg + C'(1);
            spq_pkg::CMD_REMOVE: if (!empty) occ_next = occ_reg - C'(1);
            default: occ_next = occ_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (cmd_ctl.exec)
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ctl.exec)
        begin
            status_reg   <= spq_pkg::ST_OK;
            out_id_reg   <= '0;
            out_age_reg  <= '0;
            out_pr_reg   <= '0;
            out_cond_reg <= '0;
            case (cmd_reg)
                spq_pkg::CMD_INSERT:
                    if (full) status_reg <= spq_pkg::ST_FULL;
                spq_pkg::CMD_REMOVE:
                begin
                    if (empty)
                    begin
                        status_reg <= spq_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        out_id_reg   <= 16'(q_reg[0].id);
                        out_age_reg  <= q_reg[0].age;
                        out_pr_reg   <= q_reg[0].prio;
                        out_cond_reg <= q_reg[0].cond;
                    end
                end
                spq_pkg::CMD_UPDATE:
                begin
                    if (!found)
                    begin
                        status_reg <= spq_pkg::ST_NOTFOUND;
                    end
                    else
                    begin
                        out_id_reg   <= 16'(upd_e.id);
                        out_age_reg  <= upd_e.age;
                        out_pr_reg   <= upd_e.prio;
                        out_cond_reg <= upd_e.cond;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign status        = status_reg;
    assign out_id        = out_id_reg;
    assign out_age       = out_age_reg;
    assign out_priority  = out_pr_reg;
    assign out_condition = out_cond_reg;
    assign front_valid   = (occ_reg != '0);
    assign front_id      = (occ_reg != '0) ? 16'(q_reg[0].id) : 16'd0;
    assign entry_count   = 5'(occ_reg);

endmodule

>>> sv/spq_ctrl.sv
// Handshake controller: load, execute, hold result.
module spq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output spq_pkg::dp_cmd_t cmd_ctl
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd_ctl.load = 1'b0;
        cmd_ctl.exec = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ctl.load = in_valid;
                if (in_valid) state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd_ctl.exec = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

endmodule

>>> sim/tb.sv
// Self-checking testbench for the stable priority queue top level.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_NOP = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] pid;
        logic [7:0]  age;
        logic [2:0]  prq;
        logic [2:0]  npr;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] oid;
        logic [7:0]  oage;
        logic [2:0]  opr;
        logic [1:0]  ocond;
        logic        fvalid;
        logic [15:0] fid;
        logic [4:0]  count;
    } response_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  cmd;
    logic [15:0] patient_id;
    logic [7:0]  patient_age;
    logic [2:0]  priority_req;
    logic [2:0]  new_priority;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [7:0]  out_age;
    logic [2:0]  out_priority;
    logic [1:0]  out_condition;
    logic        front_valid;
    logic [15:0] front_id;
    logic [4:0]  entry_count;

    stable_priority_queue_top dut (.*);

    // Shadow copy of the queue contents
    logic [2:0]  sh_key  [spq_pkg::QUEUE_DEPTH];
    logic [2:0]  sh_prio [spq_pkg::QUEUE_DEPTH];
    logic [15:0] sh_id   [spq_pkg::QUEUE_DEPTH];
    logic [7:0]  sh_age  [spq_pkg::QUEUE_DEPTH];
    logic [1:0]  sh_cond [spq_pkg::QUEUE_DEPTH];
    int          sh_count;

    request_t    pending_reqs[$];
    response_t   expected_results[$];
    int          idle_pct;
    int          stall_pct;
    int          mismatches;
    int          results_seen;
    int          n_ins, n_rem, n_upd, n_full, n_under, n_miss;

    function automatic logic [1:0] condition_for(input logic [2:0] pr);
        return (pr >= 3'd1 && pr <= 3'd3) ? pr[1:0] : 2'd0;
    endfunction

    // Apply one command to the shadow queue and return the expected result
    function automatic response_t apply_request(input request_t rq);
        response_t r;
        int pos;
        int hit;
        r = '0;
        case (rq.cmd)
            spq_pkg::CMD_INSERT:
            begin
                n_ins++;
                if (sh_count >= spq_pkg::QUEUE_DEPTH)
                begin
                    r.status = spq_pkg::ST_FULL;
                    n_full++;
                end
                else
                begin
                    pos = 0;
                    while (pos < sh_count && sh_key[pos] >= rq.prq)
                        pos++;
                    for (int i = sh_count; i > pos; i--)
                    begin
                        sh_key[i]  = sh_key[i-1];
                        sh_prio[i] = sh_prio[i-1];
                        sh_id[i]   = sh_id[i-1];
                        sh_age[i]  = sh_age[i-1];
                        sh_cond[i] = sh_cond[i-1];
                    end
                    sh_key[pos]  = rq.prq;
                    sh_prio[pos] = rq.prq;
                    sh_id[pos]   = rq.pid;
                    sh_age[pos]  = rq.age;
                    sh_cond[pos] = condition_for(rq.prq);
                    sh_count++;
                end
            end
            spq_pkg::CMD_REMOVE:
            begin
                n_rem++;
                if (sh_count == 0)
                begin
                    r.status = spq_pkg::ST_UNDERFLOW;
                    n_under++;
                end
                else
                begin
                    r.oid   = sh_id[0];
                    r.oage  = sh_age[0];
                    r.opr   = sh_prio[0];
                    r.ocond = sh_cond[0];
                    for (int i = 0; i + 1 < sh_count; i++)
                    begin
                        sh_key[i]  = sh_key[i+1];
                        sh_prio[i] = sh_prio[i+1];
                        sh_id[i]   = sh_id[i+1];
                        sh_age[i]  = sh_age[i+1];
                        sh_cond[i] = sh_cond[i+1];
                    end
                    sh_count--;
                end
            end
            spq_pkg::CMD_UPDATE:
            begin
                n_upd++;
                hit = -1;
                for (int i = 0; i < sh_count; i++)
                    if (hit < 0 && sh_id[i] == rq.pid && sh_age[i] == rq.age
                        && sh_prio[i] == rq.prq)
                        hit = i;
                if (hit < 0)
                begin
                    r.status = spq_pkg::ST_NOTFOUND;
                    n_miss++;
                end
                else
                begin
                    sh_prio[hit] = rq.npr;
                    if (condition_for(rq.npr) != 2'd0)
                        sh_cond[hit] = condition_for(rq.npr);
                    r.oid   = sh_id[hit];
                    r.oage  = sh_age[hit];
                    r.opr   = sh_prio[hit];
                    r.ocond = sh_cond[hit];
                end
            end
            default: ;
        endcase
        r.fvalid = (sh_count != 0);
        r.fid    = (sh_count != 0) ? sh_id[0] : 16'd0;
        r.count  = sh_count[4:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    always #1 clk = ~clk;

    // Driver: hands out queued commands, idling at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                request_t rq;
                rq = pending_reqs.pop_front();
                expected_results = {expected_results, apply_request(rq)};
                in_valid     <= 1'b1;
                cmd          <= rq.cmd;
                patient_id   <= rq.pid;
                patient_age  <= rq.age;
                priority_req <= rq.prq;
                new_priority <= rq.npr;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each taken result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result", 32'(status), 32'd0);
                end
                else
                begin
                    response_t e;
                    e = expected_results.pop_front();
                    if (status !== e.status)
                        report_mismatch("status", 32'(status), 32'(e.status));
                    if (out_id !== e.oid)
                        report_mismatch("out_id", 32'(out_id), 32'(e.oid));
                    if (out_age !== e.oage)
                        report_mismatch("out_age", 32'(out_age), 32'(e.oage));
                    if (out_priority !== e.opr)
                        report_mismatch("out_priority", 32'(out_priority), 32'(e.opr));
                    if (out_condition !== e.ocond)
                        report_mismatch("out_condition", 32'(out_condition),
                                        32'(e.ocond));
                    if (front_valid !== e.fvalid)
                        report_mismatch("front_valid", 32'(front_valid), 32'(e.fvalid));
                    if (front_id !== e.fid)
                        report_mismatch("front_id", 32'(front_id), 32'(e.fid));
                    if (entry_count !== e.count)
                        report_mismatch("entry_count", 32'(entry_count), 32'(e.count));
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    function automatic request_t make_req(input logic [1:0] c, input logic [15:0] id,
                                          input logic [7:0] a, input logic [2:0] p,
                                          input logic [2:0] np);
        request_t rq;
        rq.cmd = c;
        rq.pid = id;
        rq.age = a;
        rq.prq = p;
        rq.npr = np;
        return rq;
    endfunction

    // Random command mix; updates mostly aim at live entries
    task automatic queue_random(input int count);
        request_t live[$];
        request_t rq;
        int sel;
        int k;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(99);
            rq = make_req(spq_pkg::CMD_INSERT, 16'($urandom), 8'($urandom),
                          3'($urandom), 3'($urandom));
            if (sel < 40)
            begin
                live = {live, rq};
                if (live.size() > 32)
                    void'(live.pop_front());
            end
            else if (sel < 65)
            begin
                rq.cmd = spq_pkg::CMD_REMOVE;
            end
            else if (sel < 90 && live.size() != 0)
            begin
                k = $urandom_range(live.size() - 1);
                rq.cmd = spq_pkg::CMD_UPDATE;
                rq.pid = live[k].pid;
                rq.age = live[k].age;
                rq.prq = live[k].prq;
                live[k].prq = rq.npr;
            end
            else if (sel < 97)
            begin
                rq.cmd = spq_pkg::CMD_UPDATE;
            end
            else
            begin
                rq.cmd = CMD_NOP;
            end
            pending_reqs = {pending_reqs, rq};
        end
    endtask

    task automatic add_req(input request_t rq);
        pending_reqs = {pending_reqs, rq};
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        cmd = spq_pkg::CMD_INSERT;
        patient_id = '0;
        patient_age = '0;
        priority_req = '0;
        new_priority = '0;
        idle_pct = 0;
        stall_pct = 0;
        mismatches = 0;
        results_seen = 0;
        sh_count = 0;
        n_ins = 0;
        n_rem = 0;
        n_upd = 0;
        n_full = 0;
        n_under = 0;
        n_miss = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: underflow, miss on empty, no-op, extremes, fill to full
        add_req(make_req(spq_pkg::CMD_REMOVE, 16'hFFFF, 8'hFF, 3'd7, 3'd7));
        add_req(make_req(spq_pkg::CMD_UPDATE, 16'h0000, 8'h00, 3'd0, 3'd1));
        add_req(make_req(CMD_NOP, 16'hFFFF, 8'hFF, 3'd7, 3'd7));
        for (int i = 0; i < 17; i++)
            add_req(make_req(spq_pkg::CMD_INSERT, (i == 0) ? 16'hFFFF : i[15:0],
                             (i == 0) ? 8'hFF : i[7:0], 3'(i % 8), 3'd0));
        add_req(make_req(spq_pkg::CMD_UPDATE, 16'hFFFF, 8'hFF, 3'd0, 3'd3));
        add_req(make_req(spq_pkg::CMD_UPDATE, 16'hFFFF, 8'hFF, 3'd3, 3'd6));
        add_req(make_req(spq_pkg::CMD_UPDATE, 16'd7, 8'd7, 3'd7, 3'd2));
        add_req(make_req(spq_pkg::CMD_REMOVE, 16'd0, 8'd0, 3'd0, 3'd0));
        wait_drained();

        // Random phases with varied idling and output stalls; drain between them
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = (ph == 1) ? 54 : (ph == 3) ? 34 : 0;
            stall_pct = (ph == 2) ? 54 : (ph == 3) ? 34 : 0;
            queue_random(200);
            wait_drained();
        end
        idle_pct = 0;
        stall_pct = 0;
        repeat (20) @(posedge clk);

        $display("covered %0d inserts (%0d full), %0d removes (%0d empty), %0d updates (%0d missed)",
                 n_ins, n_full, n_rem, n_under, n_upd, n_miss);
        $display("checked %0d results under four idling phases", results_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #200000;
        $display("timeout");
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
